>>> rtl/eabq_pkg.sv
`timescale 1ns / 1ps
// Shared types, event codes and register indexes for the encoder and button event qualifier.
package eabq_pkg;

    // One bit per event code; bit k of a mask stands for event code k.
    localparam int EV_W = 9;
    localparam int CODE_W = 4;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int TPD_W = 3;
    localparam int ACC_W = 4;
    localparam int LAST_CODED_BIT = 5;

    // Event queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [EV_W-1:0] ev_mask_t;
    typedef logic [CODE_W-1:0] code_t;

    // Event codes.
    localparam code_t CODE_CW = 4'd0;
    localparam code_t CODE_CCW = 4'd1;
    localparam code_t CODE_PORT_BASE = 4'd2;
    localparam code_t CODE_SWITCH = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TPD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUTTON_MASK = 2'd2;

    // Queue status seen by the back and by the top level's input stall.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Code of the lowest set bit of an event mask.
    function automatic code_t lowest_code(input ev_mask_t mask);
        code_t code;
        code = CODE_CW;
        for (int i = EV_W - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                code = CODE_W'(i);
            end
        end
        return code;
    endfunction

endpackage

>>> rtl/eabq_front.sv
`timescale 1ns / 1ps
// Front part: configuration registers, detent counting and button debounce into event masks.
module eabq_front #(
    parameter int PORT_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [eabq_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [eabq_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  accept,
    input  logic                                  poll_tick,
    input  logic                                  encoder_clk,
    input  logic                                  encoder_dt,
    input  logic [PORT_BITS-1:0]                  button_port,
    input  logic                                  switch_level,
    output logic                                  push,
    output eabq_pkg::ev_mask_t                    push_mask
);

    localparam int NCODED = (PORT_BITS < eabq_pkg::LAST_CODED_BIT + 1) ?
                            PORT_BITS : eabq_pkg::LAST_CODED_BIT + 1;

    logic                               reverse_reg;
    logic [eabq_pkg::TPD_W-1:0]         tpd_reg;
    logic [eabq_pkg::CFG_DATA_W-1:0]    bmask_reg;

    logic                               prev_clk_reg, prev_clk_next;
    logic signed [eabq_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [PORT_BITS-1:0]               prev_port_reg, prev_port_next;
    logic [PORT_BITS-1:0]               deb_port_reg, deb_port_next;
    logic                               prev_sw_reg, prev_sw_next;
    logic                               deb_sw_reg, deb_sw_next;

    logic [eabq_pkg::TPD_W-1:0]         size;
    logic signed [eabq_pkg::ACC_W:0]    size_s;
    logic signed [eabq_pkg::ACC_W:0]    step_sum;
    eabq_pkg::ev_mask_t                 mask;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg <= 1'b1;
            tpd_reg <= 3'd2;
            bmask_reg <= 8'h3F;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eabq_pkg::CFG_REVERSE:     reverse_reg <= cfg_data[0];
                eabq_pkg::CFG_TPD:         tpd_reg <= cfg_data[eabq_pkg::TPD_W-1:0];
                eabq_pkg::CFG_BUTTON_MASK: bmask_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Detent accumulator: step on a clock line change, then emit at most one turn.
    always_comb
    begin
        size = (tpd_reg == '0) ? eabq_pkg::TPD_W'(1) : tpd_reg;
        size_s = $signed({2'b00, size});
        step_sum = {acc_reg[eabq_pkg::ACC_W-1], acc_reg};
        prev_clk_next = encoder_clk;
        if (encoder_clk != prev_clk_reg)
        begin
            if (encoder_dt != encoder_clk)
            begin
                step_sum = step_sum + 5'sd1;
            end
            else
            begin
                step_sum = step_sum - 5'sd1;
            end
        end
        mask = '0;
        acc_next = step_sum[eabq_pkg::ACC_W-1:0];
        if (step_sum >= size_s)
        begin
            acc_next = eabq_pkg::ACC_W'(step_sum - size_s);
            if (reverse_reg)
            begin
                mask[eabq_pkg::CODE_CCW] = 1'b1;
            end
            else
            begin
                mask[eabq_pkg::CODE_CW] = 1'b1;
            end
        end
        else if (step_sum <= -size_s)
        begin
            acc_next = eabq_pkg::ACC_W'(step_sum + size_s);
            if (reverse_reg)
            begin
                mask[eabq_pkg::CODE_CW] = 1'b1;
            end
            else
            begin
                mask[eabq_pkg::CODE_CCW] = 1'b1;
            end
        end

        // Debounce on poll transactions only: two equal polls accept a sample.
        prev_port_next = prev_port_reg;
        deb_port_next = deb_port_reg;
        prev_sw_next = prev_sw_reg;
        deb_sw_next = deb_sw_reg;
        if (poll_tick)
        begin
            if (button_port == prev_port_reg && button_port != deb_port_reg)
            begin
                for (int b = 0; b < NCODED; b++)
                begin
                    if (bmask_reg[b] && deb_port_reg[b] && !button_port[b])
                    begin
                        mask[int'(eabq_pkg::CODE_PORT_BASE) + b] = 1'b1;
                    end
                end
                deb_port_next = button_port;
            end
            prev_port_next = button_port;
            if (switch_level == prev_sw_reg && switch_level != deb_sw_reg)
            begin
                deb_sw_next = switch_level;
                if (!switch_level)
                begin
                    mask[eabq_pkg::CODE_SWITCH] = 1'b1;
                end
            end
            prev_sw_next = switch_level;
        end
    end

    // Tracking state advances on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk_reg <= 1'b1;
            acc_reg <= '0;
            prev_port_reg <= '1;
            deb_port_reg <= '1;
            prev_sw_reg <= 1'b1;
            deb_sw_reg <= 1'b1;
        end
        else if (accept)
        begin
            prev_clk_reg <= prev_clk_next;
            acc_reg <= acc_next;
            prev_port_reg <= prev_port_next;
            deb_port_reg <= deb_port_next;
            prev_sw_reg <= prev_sw_next;
            deb_sw_reg <= deb_sw_next;
        end
    end

    // Only transactions that raise events go into the queue.
    assign push = accept && (mask != '0);
    assign push_mask = mask;

    // The accumulator never leaves -7..7.
    acc_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg != 4'sb1000)
        else $error("detent accumulator out of range");

endmodule

>>> rtl/eabq_queue.sv
`timescale 1ns / 1ps
// Short queue of event masks between the front and the back.
module eabq_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  eabq_pkg::ev_mask_t   push_mask,
    input  logic                 pop,
    output eabq_pkg::ev_mask_t   head_mask,
    output eabq_pkg::q_status_t  status
);

    eabq_pkg::ev_mask_t              entry_reg [eabq_pkg::QUEUE_DEPTH];
    logic [eabq_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [eabq_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_push, do_pop;

    assign status.full = (count_reg == eabq_pkg::QCNT_W'(eabq_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop = pop && !status.empty;
    assign head_mask = entry_reg[rd_ptr_reg];

    // Occupancy count.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= eabq_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= eabq_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_mask;
        end
    end

    count_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eabq_pkg::QCNT_W'(eabq_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    ptr_match_a: assert property (@(posedge clk) disable iff (!rst_n)
        (status.empty || status.full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/eabq_back.sv
`timescale 1ns / 1ps
// Back part: turns each queued event mask into a run of event transactions.
module eabq_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  eabq_pkg::ev_mask_t          head_mask,
    input  eabq_pkg::q_status_t         status,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [eabq_pkg::CODE_W-1:0] event_code,
    output logic                        last_event
);

    eabq_pkg::ev_mask_t  cur_mask_reg, cur_mask_next;
    logic                valid_reg, valid_next;
    eabq_pkg::code_t     code;
    eabq_pkg::ev_mask_t  rest;

    // Lowest pending event goes out first; it is the last when nothing else is left.
    assign code = eabq_pkg::lowest_code(cur_mask_reg);
    assign rest = cur_mask_reg & ~(eabq_pkg::EV_W'(1) << code);
    assign out_valid = valid_reg;
    assign event_code = code;
    assign last_event = (rest == '0);

    // Reload from the queue when idle or when the last event is taken.
    always_comb
    begin
        pop = 1'b0;
        cur_mask_next = cur_mask_reg;
        valid_next = valid_reg;
        if (!valid_reg)
        begin
            if (!status.empty)
            begin
                pop = 1'b1;
                cur_mask_next = head_mask;
                valid_next = 1'b1;
            end
        end
        else if (!out_stall)
        begin
            if (rest != '0)
            begin
                cur_mask_next = rest;
            end
            else if (!status.empty)
            begin
                pop = 1'b1;
                cur_mask_next = head_mask;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_mask_reg <= cur_mask_next;
    end

    valid_has_event_a: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cur_mask_reg != '0))
        else $error("output valid without a pending event");

endmodule

>>> rtl/encoder_and_button_event_qualifier.sv
`timescale 1ns / 1ps
// Top level of the encoder and button event qualifier.
// Accepted transactions pass the queue entry, then the back's mask register, before output.
// One input transaction per cycle is accepted while the four-entry event queue has room;
// the back emits one event per cycle while out_stall is low, one transfer for each event.
// Transactions that raise no event never enter the queue.
// Reset (rst_n, asynchronous, active low) restores the register defaults and empties the queue.
module encoder_and_button_event_qualifier #(
    parameter int PORT_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [eabq_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [eabq_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  poll_tick,
    input  logic                                  encoder_clk,
    input  logic                                  encoder_dt,
    input  logic [PORT_BITS-1:0]                  button_port,
    input  logic                                  switch_level,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [eabq_pkg::CODE_W-1:0]           event_code,
    output logic                                  last_event
);

    logic                 accept;
    logic                 push;
    logic                 pop;
    eabq_pkg::ev_mask_t   push_mask;
    eabq_pkg::ev_mask_t   head_mask;
    eabq_pkg::q_status_t  status;

    // The front stalls only when the queue is full.
    assign in_stall = status.full;
    assign accept = in_valid && !status.full;

    eabq_front #(
        .PORT_BITS(PORT_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .accept(accept),
        .poll_tick(poll_tick),
        .encoder_clk(encoder_clk),
        .encoder_dt(encoder_dt),
        .button_port(button_port),
        .switch_level(switch_level),
        .push(push),
        .push_mask(push_mask)
    );

    eabq_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_mask(push_mask),
        .pop(pop),
        .head_mask(head_mask),
        .status(status)
    );

    eabq_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head_mask(head_mask),
        .status(status),
        .pop(pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_code(event_code),
        .last_event(last_event)
    );

endmodule

>>> tb/encoder_and_button_event_qualifier_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the encoder and button event qualifier, with a built-in predictor.
module encoder_and_button_event_qualifier_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT = 35;

    // One predicted event transaction on the output side.
    typedef struct {
        eabq_pkg::code_t code;
        logic            last;
    } qual_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [eabq_pkg::CFG_INDEX_W-1:0] cfg_index = eabq_pkg::CFG_REVERSE;
    logic [eabq_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic poll_tick = 1'b0;
    logic encoder_clk = 1'b1;
    logic encoder_dt = 1'b1;
    logic [7:0] button_port = 8'hFF;
    logic switch_level = 1'b1;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [eabq_pkg::CODE_W-1:0] event_code;
    logic last_event;

    // Predictor copy of the registers and the state.
    logic       reverse_cfg;
    logic [2:0] detent_cfg;
    logic [7:0] mask_cfg;
    logic       prev_clk;
    int         detent_count;
    logic [7:0] prev_port;
    logic [7:0] deb_port;
    logic       prev_sw;
    logic       deb_sw;

    qual_event_t expected_events[$];
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;
    logic hold_active = 1'b0;

    // Stimulus-side memory of the lines, used to build well-formed sequences.
    logic       line_clk = 1'b1;
    logic       turn_up = 1'b1;
    logic [7:0] button_level = 8'hFF;
    logic       switch_hold = 1'b1;

    encoder_and_button_event_qualifier u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .poll_tick(poll_tick),
        .encoder_clk(encoder_clk),
        .encoder_dt(encoder_dt),
        .button_port(button_port),
        .switch_level(switch_level),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_code(event_code),
        .last_event(last_event)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("Mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Restore the predictor to its reset values.
    function automatic void reset_predictor();
        reverse_cfg = 1'b1;
        detent_cfg = 3'd2;
        mask_cfg = 8'h3F;
        prev_clk = 1'b1;
        detent_count = 0;
        prev_port = 8'hFF;
        deb_port = 8'hFF;
        prev_sw = 1'b1;
        deb_sw = 1'b1;
    endfunction

    // Work out the events that one accepted sample causes and queue them.
    function automatic void predict_events(input logic poll, input logic eclk, input logic dt,
                                           input logic [7:0] port, input logic sw);
        int size;
        qual_event_t batch[$];
        size = (detent_cfg == 3'd0) ? 1 : int'(detent_cfg);

        // Encoder: count clock-line changes and emit a turn per detent.
        if (eclk != prev_clk)
        begin
            if (dt != eclk)
                detent_count++;
            else
                detent_count--;
            prev_clk = eclk;
        end
        if (detent_count >= size)
        begin
            detent_count -= size;
            batch.push_back('{reverse_cfg ? eabq_pkg::CODE_CCW : eabq_pkg::CODE_CW, 1'b0});
        end
        else if (detent_count <= -size)
        begin
            detent_count += size;
            batch.push_back('{reverse_cfg ? eabq_pkg::CODE_CW : eabq_pkg::CODE_CCW, 1'b0});
        end

        // Buttons and switch are debounced on poll samples only.
        if (poll)
        begin
            if (port == prev_port && port != deb_port)
            begin
                for (int b = 0; b <= eabq_pkg::LAST_CODED_BIT; b++)
                begin
                    if (mask_cfg[b] && deb_port[b] && !port[b])
                        batch.push_back('{eabq_pkg::CODE_PORT_BASE + eabq_pkg::code_t'(b),
                                          1'b0});
                end
                deb_port = port;
            end
            prev_port = port;
            if (sw == prev_sw && sw != deb_sw)
            begin
                deb_sw = sw;
                if (!sw)
                    batch.push_back('{eabq_pkg::CODE_SWITCH, 1'b0});
            end
            prev_sw = sw;
        end

        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_events.push_back(batch[i]);
    endfunction

    // Output side: check each accepted event and choose the next stall.
    always @(posedge clk)
    begin
        qual_event_t head;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                report_mismatch($sformatf("event code %0d with nothing expected", event_code));
            end
            else
            begin
                head = expected_events.pop_front();
                if (event_code !== head.code)
                    report_mismatch($sformatf("event_code %0d, expected %0d",
                                              event_code, head.code));
                if (last_event !== head.last)
                    report_mismatch($sformatf("last_event %0b, expected %0b",
                                              last_event, head.last));
            end
        end
        out_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
    end

    // Offer one sample transaction and wait until it is accepted.
    task automatic send_sample(input logic poll, input logic eclk, input logic dt,
                               input logic [7:0] port, input logic sw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        poll_tick <= poll;
        encoder_clk <= eclk;
        encoder_dt <= dt;
        button_port <= port;
        switch_level <= sw;
        do
            @(posedge clk);
        while (in_stall);
        line_clk = eclk;
        predict_events(poll, eclk, dt, port, sw);
    endtask

    // Stop offering, wait for every expected event, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register while the block is idle and mirror it in the predictor.
    task automatic write_register(input logic [eabq_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [eabq_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (index)
            eabq_pkg::CFG_REVERSE: reverse_cfg = data[0];
            eabq_pkg::CFG_TPD: detent_cfg = data[2:0];
            eabq_pkg::CFG_BUTTON_MASK: mask_cfg = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic rev, input logic [2:0] tpd, input logic [7:0] mask);
        write_register(eabq_pkg::CFG_REVERSE, {7'd0, rev});
        write_register(eabq_pkg::CFG_TPD, {5'd0, tpd});
        write_register(eabq_pkg::CFG_BUTTON_MASK, mask);
    endtask

    // Hold the output stalled for a number of cycles.
    task automatic hold_output(input int cycles);
        hold_active <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_active <= 1'b0;
    endtask

    // Random samples, mostly clean quadrature motion and held button levels.
    task automatic run_random_phase(input int count);
        logic poll;
        logic eclk;
        logic dt;
        logic [7:0] port;
        logic sw;
        repeat (count)
        begin
            // Encoder lines: clean steps, data-line wiggles, or noise.
            if ($urandom_range(99) < 20)
                turn_up = !turn_up;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    eclk = !line_clk;
                    dt = turn_up ? !eclk : eclk;
                end
                7:
                begin
                    eclk = line_clk;
                    dt = 1'($urandom_range(1));
                end
                default:
                begin
                    eclk = 1'($urandom_range(1));
                    dt = 1'($urandom_range(1));
                end
            endcase

            // Button and switch levels change now and then and are held otherwise.
            if ($urandom_range(99) < 12)
                button_level = ($urandom_range(1) == 1) ? 8'($urandom)
                                                        : button_level ^ (8'h1 << $urandom_range(7));
            if ($urandom_range(99) < 12)
                switch_hold = !switch_hold;
            port = ($urandom_range(99) < 8) ? 8'($urandom) : button_level;
            sw = ($urandom_range(99) < 8) ? 1'($urandom_range(1)) : switch_hold;
            poll = ($urandom_range(99) < 45);
            send_sample(poll, eclk, dt, port, sw);
        end
    endtask

    // Reset defaults: detent size two, reversed direction.
    task automatic test_default_turns();
        send_sample(1'b0, 1'b0, 1'b1, 8'hFF, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0, 8'hFF, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0, 8'hFF, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1, 8'hFF, 1'b1);
        drain();
    endtask

    // Presses under the default mask; upper port bits never emit; non-poll samples are ignored.
    task automatic test_button_presses();
        send_sample(1'b1, 1'b1, 1'b1, 8'hFE, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 8'hFE, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 8'h3E, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 8'h3E, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1, 8'hFF, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1, 8'hFF, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);
        drain();
    endtask

    // Zero detent size acts as one; full mask; unreversed direction.
    task automatic test_register_extremes();
        configure(1'b0, 3'd0, 8'hFF);
        send_sample(1'b0, 1'b0, 1'b1, 8'hFF, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 8'h00, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 8'h00, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);
        drain();
    endtask

    // Largest detent size, then lowered mid-count so turns drain one per sample.
    task automatic test_detent_lowered();
        logic eclk;
        configure(1'b1, 3'd7, 8'h3F);
        eclk = line_clk;
        repeat (5)
        begin
            eclk = !eclk;
            send_sample(1'b0, eclk, !eclk, 8'hFF, 1'b1);
        end
        drain();
        write_register(eabq_pkg::CFG_TPD, 8'd1);
        repeat (6)
            send_sample(1'b0, eclk, !eclk, 8'hFF, 1'b1);
        drain();
    endtask

    // One sample that raises a turn, six presses and the switch press at once.
    task automatic test_full_burst();
        configure(1'b1, 3'd1, 8'hFF);
        send_sample(1'b1, line_clk, line_clk, 8'h00, 1'b0);
        send_sample(1'b1, !line_clk, line_clk, 8'h00, 1'b0);
        send_sample(1'b1, line_clk, line_clk, 8'hFF, 1'b1);
        send_sample(1'b1, line_clk, line_clk, 8'hFF, 1'b1);
        drain();
    endtask

    // Output held off for a long stretch while turn events keep arriving.
    task automatic test_backpressure();
        configure(1'b0, 3'd1, 8'h3F);
        send_idle_pct = 0;
        fork
            hold_output(80);
            begin
                repeat (24)
                    send_sample(1'b0, !line_clk, line_clk, 8'hFF, 1'b1);
            end
        join
        send_idle_pct = IDLE_PCT;
        drain();
    endtask

    // A stretch with no idling on either side.
    task automatic test_no_idle_stretch();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(30);
        drain();
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
    endtask

    // Random phases under several register settings.
    task automatic test_random_phases();
        configure(1'b0, 3'd1, 8'hFF);
        run_random_phase(18);
        drain();
        configure(1'b1, 3'd7, 8'h00);
        run_random_phase(18);
        drain();
        configure(1'b0, 3'd4, 8'($urandom));
        run_random_phase(18);
        drain();
        configure(1'b1, 3'd0, 8'h3F);
        run_random_phase(18);
        drain();
        configure(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom));
        run_random_phase(18);
        drain();
    endtask

    initial
    begin
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_turns();
        test_button_presses();
        test_register_extremes();
        test_detent_lowered();
        test_full_burst();
        test_backpressure();
        test_no_idle_stretch();
        test_random_phases();

        drain();
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", expected_events.size()));
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> encoder_and_button_event_qualifier.f
rtl/eabq_pkg.sv
rtl/eabq_front.sv
rtl/eabq_queue.sv
rtl/eabq_back.sv
rtl/encoder_and_button_event_qualifier.sv
tb/encoder_and_button_event_qualifier_test.sv
